// ===== design/gre_pkg.sv =====
// Shared types and codes for the graph reachability engine.
`default_nettype none

package gre_pkg;

   // Vertex id width and the number of ids it can name.
   localparam int IdWidth = 6;
   localparam int IdCount = 64;

   // Default vertex capacity.
   localparam int DefaultVertices = 64;

   // Request type codes.
   localparam logic [1:0] ReqInit   = 2'd0;
   localparam logic [1:0] ReqAdd    = 2'd1;
   localparam logic [1:0] ReqRemove = 2'd2;
   localparam logic [1:0] ReqQuery  = 2'd3;

   // Adjacency read address select codes.
   localparam logic [1:0] RdSelA    = 2'd0;
   localparam logic [1:0] RdSelB    = 2'd1;
   localparam logic [1:0] RdSelPick = 2'd2;

   // Adjacency write select codes.
   localparam logic WrSelA = 1'b0;
   localparam logic WrSelB = 1'b1;

   // Request beat.
   typedef struct packed {
      logic [1:0]         req_type;
      logic [IdCount-1:0] vertex_mask;
      logic [IdWidth-1:0] vertex_a;
      logic [IdWidth-1:0] vertex_b;
   } gre_req_type;

   // Response beat.
   typedef struct packed {
      logic status;
      logic path_found;
   } gre_rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;
      logic       init;
      logic       remove;
      logic       rd_en;
      logic [1:0] rd_sel;
      logic       wr_en;
      logic       wr_sel;
      logic       q_start;
      logic       q_expand;
      logic       set_res;
      logic       res_status;
      logic       res_found;
      logic       push;
   } gre_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] req_type;
      logic       a_ok;
      logic       b_ok;
      logic       same_ends;
      logic       pending_empty;
      logic       target_hit;
      logic       out_free;
   } gre_stat_type;

endpackage

`default_nettype wire

// ===== design/gre_ctrl.sv =====
// Controller state machine for the graph reachability engine.
`default_nettype none

module gre_ctrl
   import gre_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output      logic         req_ready,
   input  wire gre_stat_type stat,
   output      gre_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_ADD_A  = 3'd2;
   localparam logic [2:0] S_ADD_B  = 3'd3;
   localparam logic [2:0] S_PICK   = 3'd4;
   localparam logic [2:0] S_EXPAND = 3'd5;
   localparam logic [2:0] S_FINISH = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.set_res = 1'b1;
            state_in    = S_FINISH;
            unique case (stat.req_type)
               ReqInit: begin
                  cmd.init = 1'b1;
               end
               ReqAdd: begin
                  if (stat.a_ok && stat.b_ok) begin
                     cmd.set_res = 1'b0;
                     cmd.rd_en   = 1'b1;
                     cmd.rd_sel  = RdSelA;
                     state_in    = S_ADD_A;
                  end else begin
                     cmd.res_status = 1'b1;
                  end
               end
               ReqRemove: begin
                  if (stat.a_ok) begin
                     cmd.remove = 1'b1;
                  end else begin
                     cmd.res_status = 1'b1;
                  end
               end
               ReqQuery: begin
                  if (!(stat.a_ok && stat.b_ok)) begin
                     cmd.res_status = 1'b1;
                  end else if (stat.same_ends) begin
                     cmd.res_found = 1'b1;
                  end else begin
                     cmd.set_res = 1'b0;
                     cmd.q_start = 1'b1;
                     state_in    = S_PICK;
                  end
               end
               default: begin
                  cmd.res_status = 1'b1;
               end
            endcase
         end
         S_ADD_A: begin
            // Row a is in the read register; write it back and fetch row b.
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WrSelA;
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RdSelB;
            state_in   = S_ADD_B;
         end
         S_ADD_B: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WrSelB;
            cmd.set_res = 1'b1;
            state_in    = S_FINISH;
         end
         S_PICK: begin
            // Stop on a hit or an empty frontier, else fetch the next row.
            if (stat.target_hit) begin
               cmd.set_res   = 1'b1;
               cmd.res_found = 1'b1;
               state_in      = S_FINISH;
            end else if (stat.pending_empty) begin
               cmd.set_res = 1'b1;
               state_in    = S_FINISH;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RdSelPick;
               state_in   = S_EXPAND;
            end
         end
         S_EXPAND: begin
            cmd.q_expand = 1'b1;
            state_in     = S_PICK;
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/gre_datapath.sv =====
// Datapath for the graph reachability engine: graph storage, search state, result register.
`default_nettype none

module gre_datapath
   import gre_pkg::*;
#(
   parameter int VERTICES = DefaultVertices
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire gre_req_type  req_data,
   input  wire gre_cmd_type  cmd,
   output      gre_stat_type stat,
   input  wire logic         rsp_ready,
   output      logic         rsp_valid,
   output      gre_rsp_type  rsp_data
);

   // Only ids below both the capacity and the id range can be present.
   localparam int Rows  = (VERTICES > IdCount) ? IdCount : VERTICES;
   localparam int AddrW = (Rows > 1) ? $clog2(Rows) : 1;

   function automatic logic [IdCount-1:0] id_bit(input logic [IdWidth-1:0] id);
      return {{(IdCount-1){1'b0}}, 1'b1} << id;
   endfunction

   // Captured request.
   logic [1:0]         type_ff;
   logic [IdCount-1:0] mask_ff;
   logic [IdWidth-1:0] a_ff;
   logic [IdWidth-1:0] b_ff;

   // Graph and search state.
   logic [IdCount-1:0] present_ff;
   logic [IdCount-1:0] visited_ff;
   logic [IdCount-1:0] pending_ff;
   logic [Rows-1:0]    row_valid_ff;
   logic [IdCount-1:0] adj_mem_ff [Rows];

   // Adjacency read port.
   logic [IdCount-1:0] rd_q_ff;
   logic               rd_valid_ff;
   logic [AddrW-1:0]   rd_addr;
   logic [IdCount-1:0] row_data;

   // Adjacency write port.
   logic [AddrW-1:0]   wr_addr;
   logic [IdCount-1:0] wr_data;

   // Frontier selection.
   logic [IdWidth-1:0] pick_id;
   logic [IdCount-1:0] usable;
   logic [IdCount-1:0] fresh;

   // Result and output register.
   logic        res_status_ff;
   logic        res_found_ff;
   logic        rsp_valid_ff;
   gre_rsp_type rsp_data_ff;

   // Ids this configuration can hold.
   always_comb begin
      for (int i = 0; i < IdCount; i++) begin
         usable[i] = (i < Rows);
      end
   end

   // Lowest pending vertex.
   always_comb begin
      pick_id = '0;
      for (int i = IdCount - 1; i >= 0; i--) begin
         if (pending_ff[i]) begin
            pick_id = IdWidth'(i);
         end
      end
   end

   // Read address and write row selection.
   always_comb begin
      case (cmd.rd_sel)
         RdSelA:    rd_addr = a_ff[AddrW-1:0];
         RdSelB:    rd_addr = b_ff[AddrW-1:0];
         default:   rd_addr = pick_id[AddrW-1:0];
      endcase
   end

   // A row never written since the last init reads as empty.
   assign row_data = rd_valid_ff ? rd_q_ff : '0;

   always_comb begin
      if (cmd.wr_sel == WrSelA) begin
         wr_addr = a_ff[AddrW-1:0];
         wr_data = row_data | id_bit(b_ff);
      end else begin
         wr_addr = b_ff[AddrW-1:0];
         wr_data = row_data | id_bit(a_ff);
      end
   end

   assign fresh = row_data & present_ff & ~visited_ff;

   // Adjacency memory with registered read data.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         adj_mem_ff[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_q_ff <= adj_mem_ff[rd_addr];
      end
   end

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff <= req_data.req_type;
         mask_ff <= req_data.vertex_mask;
         a_ff    <= req_data.vertex_a;
         b_ff    <= req_data.vertex_b;
      end
   end

   // Presence, row valid bits and search state.
   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff   <= '0;
         row_valid_ff <= '0;
         visited_ff   <= '0;
         pending_ff   <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (cmd.init) begin
            present_ff   <= mask_ff & usable;
            row_valid_ff <= '0;
         end else if (cmd.remove) begin
            // Stale row and column bits stay masked by presence until the next init.
            present_ff <= present_ff & ~id_bit(a_ff);
         end
         if (cmd.wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
         if (cmd.rd_en) begin
            rd_valid_ff <= row_valid_ff[rd_addr];
         end
         if (cmd.q_start) begin
            visited_ff <= id_bit(a_ff);
            pending_ff <= id_bit(a_ff);
         end else if (cmd.rd_en && cmd.rd_sel == RdSelPick) begin
            pending_ff <= pending_ff & ~id_bit(pick_id);
         end else if (cmd.q_expand) begin
            visited_ff <= visited_ff | fresh;
            pending_ff <= pending_ff | fresh;
         end
      end
   end

   // Result staging.
   always_ff @(posedge clock) begin
      if (cmd.set_res) begin
         res_status_ff <= cmd.res_status;
         res_found_ff  <= cmd.res_found;
      end
   end

   // Output register; a new beat may load while the old one is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         rsp_data_ff.status     <= res_status_ff;
         rsp_data_ff.path_found <= res_found_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Status back to the controller. Init is loaded from the held request beat.
   assign stat.req_type      = type_ff;
   assign stat.a_ok          = present_ff[a_ff];
   assign stat.b_ok          = present_ff[b_ff];
   assign stat.same_ends     = (a_ff == b_ff);
   assign stat.pending_empty = (pending_ff == '0);
   assign stat.target_hit    = visited_ff[b_ff];
   assign stat.out_free      = !rsp_valid_ff || rsp_ready;

endmodule

`default_nettype wire

// ===== design/graph_reachability_engine.sv =====
// Top level of the graph reachability engine.
//
//   Channel   Direction  Handshake            Beat
//   req_      in         req_valid/req_ready  gre_req_type: type, mask, vertex a, vertex b
//   rsp_      out        rsp_valid/rsp_ready  gre_rsp_type: status, path found
//
// One request is worked at a time. Init, remove and rejected requests go from decode to
// finish; add edge updates row a, then row b; a query alternates pick and expand, one
// vertex at a time, as the adjacency memory has a single read port.
// Reset is synchronous and clears presence, row valid bits and all control state.
// A waiting response does not block intake; only finishing the next one waits for it.
`default_nettype none

module graph_reachability_engine
   import gre_pkg::*;
#(
   parameter int VERTICES = DefaultVertices
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire gre_req_type req_data,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      gre_rsp_type rsp_data
);

   gre_cmd_type  cmd;
   gre_stat_type stat;

   // Sequencer.
   gre_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Storage and search datapath.
   gre_datapath #(
      .VERTICES (VERTICES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
